@@ design/icb_pkg.sv @@
// Package for the identifier census bitmap.
// Holds the word geometry, field widths, command and status codes and state type.
// No dependencies.
`timescale 1ns / 1ps

package icb_pkg;

	localparam int WORD_BITS   = 64;
	localparam int OFF_BITS    = $clog2(WORD_BITS);
	localparam int ID_BITS_DEF = 16;
	localparam int PID_W       = 16;
	localparam int WIDX_W      = 10;
	localparam int BOUND_W     = 17;
	localparam int STAT_W      = 2;
	localparam int CMD_W       = 2;
	localparam int IN_DATA_W   = 32;
	localparam int IN_USER_W   = 3;
	localparam int OUT_DATA_W  = 88;
	localparam int OUT_USER_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_MARK   = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_CLEAN = 2'd0,
		STAT_DUP   = 2'd1,
		STAT_BAD   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

@@ design/icb_window.sv @@
// Missing-mask builder for one bitmap word of the identifier census.
// Depends on icb_pkg for word geometry and field widths.
`timescale 1ns / 1ps

module icb_window (
	input  logic                            en,
	input  logic [icb_pkg::WORD_BITS-1:0]   word,
	input  logic [icb_pkg::WIDX_W-1:0]      widx,
	input  logic [icb_pkg::BOUND_W-1:0]     bound,
	output logic [icb_pkg::WORD_BITS-1:0]   mask
);

	logic [icb_pkg::BOUND_W-1:0]   lo;
	logic [icb_pkg::BOUND_W-1:0]   span;
	logic                          above;
	logic                          full;
	logic [icb_pkg::WORD_BITS-1:0] below;

	always_comb begin
		lo    = icb_pkg::BOUND_W'(widx) << icb_pkg::OFF_BITS;
		above = bound > lo;
		span  = bound - lo;
		full  = span >= icb_pkg::BOUND_W'(icb_pkg::WORD_BITS);
		below = full ? '1 : ~({icb_pkg::WORD_BITS{1'b1}} << span[icb_pkg::OFF_BITS-1:0]);
		mask  = (en && above) ? (~word & below) : '0;
	end

endmodule

@@ design/id_census_bitmap.sv @@
// Top level of the identifier census bitmap scoreboard.
// Depends on icb_pkg and icb_window; holds the bitmap memory and control.
`timescale 1ns / 1ps

// Each item runs in two steps: its bitmap word is read from the synchronous
// memory on accept; then, once the result register is free, it is modified,
// written back and the result register loaded. No new item is taken until then.
// One result beat comes out per item. After reset and after every clear item the
// block zeroes all 2^ID_BITS/64 words (1024 at the default) one word per cycle and
// holds s_axis_tready low meanwhile; the clear item's result is registered first.
module id_census_bitmap #(
	parameter int ID_BITS = icb_pkg::ID_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [15:0] point_id, [25:16] word_index, [31:26] zero
	input  logic [icb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [1:0] command, [2] id_valid
	input  logic [icb_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [16:0] upper_bound, [80:17] missing_mask, [87:81] zero
	output logic [icb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// [1:0] census_status, [2] was_duplicate
	output logic [icb_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

	localparam int NUM_WORDS = ((1 << ID_BITS) + icb_pkg::WORD_BITS - 1) / icb_pkg::WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
	localparam logic [icb_pkg::PID_W-1:0] ID_MASK =
		(ID_BITS >= icb_pkg::PID_W) ? '1 : icb_pkg::PID_W'((1 << ID_BITS) - 1);

	// input unpack
	icb_pkg::cmd_t                cmd_in;
	logic                         idv_in;
	logic [icb_pkg::PID_W-1:0]    pid_in;
	logic [icb_pkg::WIDX_W-1:0]   widx_in;
	logic                         accept;
	logic [AW-1:0]                rd_addr;

	// stage 1
	icb_pkg::cmd_t                cmd_s1;
	logic                         idv_s1;
	logic [icb_pkg::PID_W-1:0]    pid_s1;
	logic [icb_pkg::WIDX_W-1:0]   widx_s1;
	logic                         range_s1;
	logic [AW-1:0]                addr_s1;
	logic [icb_pkg::WORD_BITS-1:0] rd_data_s1;

	// control and state
	icb_pkg::state_t              state_q, state_next;
	logic [AW-1:0]                sweep_q;
	icb_pkg::status_t             status_q, status_next;
	logic [icb_pkg::BOUND_W-1:0]  bound_q, bound_next;
	logic                         adv;

	// execute
	logic [icb_pkg::WORD_BITS-1:0] bit_vec;
	logic                          hit;
	logic                          live;
	logic                          do_mark;
	logic                          bad_mark;
	logic                          dup;
	logic [icb_pkg::BOUND_W-1:0]   pid_plus;
	logic                          rep_en;
	logic [icb_pkg::WORD_BITS-1:0] miss;

	// memory write port
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [icb_pkg::WORD_BITS-1:0] wr_data;
	logic [icb_pkg::WORD_BITS-1:0] mem [NUM_WORDS];

	// output register
	logic                          out_valid_q;
	icb_pkg::status_t              stat_out_q;
	logic                          dup_out_q;
	logic [icb_pkg::BOUND_W-1:0]   bound_out_q;
	logic [icb_pkg::WORD_BITS-1:0] miss_out_q;

	assign cmd_in  = icb_pkg::cmd_t'(s_axis_tuser[1:0]);
	assign idv_in  = s_axis_tuser[2];
	assign pid_in  = s_axis_tdata[15:0] & ID_MASK;
	assign widx_in = s_axis_tdata[25:16];
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign rd_addr = (cmd_in == icb_pkg::CMD_MARK) ? AW'(pid_in >> icb_pkg::OFF_BITS)
	                                               : AW'(widx_in);

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_in;
			idv_s1   <= idv_in;
			pid_s1   <= pid_in;
			widx_s1  <= widx_in;
			range_s1 <= int'(widx_in) < NUM_WORDS;
			addr_s1  <= rd_addr;
		end
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (accept)
			rd_data_s1 <= mem[rd_addr];
	end

	always_comb begin
		bit_vec  = icb_pkg::WORD_BITS'(1) << pid_s1[icb_pkg::OFF_BITS-1:0];
		hit      = |(rd_data_s1 & bit_vec);
		live     = (cmd_s1 == icb_pkg::CMD_MARK) && (status_q != icb_pkg::STAT_BAD);
		do_mark  = live && idv_s1;
		bad_mark = live && !idv_s1;
		dup      = do_mark && hit;
		pid_plus = icb_pkg::BOUND_W'(pid_s1) + icb_pkg::BOUND_W'(1);
		rep_en   = (cmd_s1 == icb_pkg::CMD_REPORT) && (status_q != icb_pkg::STAT_BAD)
		           && range_s1;

		status_next = status_q;
		bound_next  = bound_q;
		if (cmd_s1 == icb_pkg::CMD_CLEAR) begin
			status_next = icb_pkg::STAT_CLEAN;
			bound_next  = '0;
		end else if (bad_mark) begin
			status_next = icb_pkg::STAT_BAD;
		end else if (do_mark) begin
			if (hit)
				status_next = icb_pkg::STAT_DUP;
			if (pid_plus > bound_q)
				bound_next = pid_plus;
		end
	end

	icb_window u_window (
		.en    (rep_en),
		.word  (rd_data_s1),
		.widx  (widx_s1),
		.bound (bound_q),
		.mask  (miss)
	);

	// next state and write port
	always_comb begin
		state_next    = state_q;
		s_axis_tready = 1'b0;
		adv           = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = addr_s1;
		wr_data       = rd_data_s1 | bit_vec;
		case (state_q)
			icb_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
				if (sweep_q == LAST_WORD)
					state_next = icb_pkg::ST_IDLE;
			end
			icb_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_next = icb_pkg::ST_EXEC;
			end
			icb_pkg::ST_EXEC: begin
				adv   = !out_valid_q || m_axis_tready;
				wr_en = adv && do_mark;
				if (adv)
					state_next = (cmd_s1 == icb_pkg::CMD_CLEAR) ? icb_pkg::ST_CLEAR
					                                            : icb_pkg::ST_IDLE;
			end
			default: state_next = icb_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= icb_pkg::ST_CLEAR;
			sweep_q  <= '0;
			status_q <= icb_pkg::STAT_CLEAN;
			bound_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == icb_pkg::ST_CLEAR)
				sweep_q <= (sweep_q == LAST_WORD) ? '0 : sweep_q + AW'(1);
			if (adv) begin
				status_q <= status_next;
				bound_q  <= bound_next;
			end
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stat_out_q  <= status_next;
			dup_out_q   <= dup;
			bound_out_q <= bound_next;
			miss_out_q  <= miss;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {dup_out_q, stat_out_q};
	assign m_axis_tdata  = {{(icb_pkg::OUT_DATA_W - icb_pkg::WORD_BITS - icb_pkg::BOUND_W){1'b0}},
	                        miss_out_q, bound_out_q};

	// sticky error holds until a clear completes
	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == icb_pkg::STAT_BAD && !(adv && cmd_s1 == icb_pkg::CMD_CLEAR))
		|=> status_q == icb_pkg::STAT_BAD)
		else $error("error status dropped without clear");

	// bound only grows between clears
	a_bound_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && cmd_s1 == icb_pkg::CMD_CLEAR) |=> bound_q >= $past(bound_q))
		else $error("upper bound decreased");

	// nothing reported or flagged once in error
	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1:0] == icb_pkg::STAT_BAD)
		|-> (!m_axis_tuser[2] && m_axis_tdata[80:17] == '0))
		else $error("duplicate or mask reported in error state");

	// a completed clear starts the sweep from word zero
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1 == icb_pkg::CMD_CLEAR)
		|=> (state_q == icb_pkg::ST_CLEAR && sweep_q == '0 && bound_q == '0))
		else $error("clear did not start sweep");

	// no input taken while the sweep runs
	a_no_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == icb_pkg::ST_CLEAR) |-> !accept)
		else $error("input accepted during clear sweep");

endmodule
